FILE: hw/rtl/bzd_pkg.sv
// ----------------------------------------------------------------------------
// bzd_pkg
// Shared types and constants for the binary to zoned decimal text converter.
// ----------------------------------------------------------------------------
package bzd_pkg;

	// Input value width and the most decimal digits it can have
	localparam int VALUE_W     = 31;
	localparam int BCD_MAX     = 10;
	localparam int SHIFT_CNT_W = $clog2(VALUE_W);

	// Default digit window
	localparam int MAX_DIGITS_DEF = 10;

	// Stream widths
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;

	// ASCII codes
	localparam logic [7:0] ZONE_CHAR = 8'd70;   // 'F'
	localparam logic [7:0] ZERO_CHAR = 8'd48;   // '0'
	localparam logic [7:0] NINE_CHAR = 8'd57;   // '9'
	localparam logic [7:0] NUL_CHAR  = 8'd0;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_EMIT  = 4'b1000
	} bzd_state_t;

endpackage

FILE: hw/rtl/binary_to_zoned_decimal_text.sv
// ----------------------------------------------------------------------------
// binary_to_zoned_decimal_text
// Converts a 31-bit unsigned integer to zoned decimal text, one digit pair
// ('F' zone, ASCII digit) per output item, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one value per item in s_tdata[30:0]; bit 31 is
//   ignored. Master stream (m_*) returns one item per decimal digit:
//   m_tdata[7:0] = zone 'F', m_tdata[15:8] = ASCII digit, m_tlast marks the
//   final digit of a value, m_tuser flags the single empty item of a zero
//   input (digit byte 0).
//   A value wider than MAX_DIGITS digits yields only its low MAX_DIGITS
//   digits, leading zeros in that window included.
//   Timing: after an item is accepted, a double-dabble unit runs one shift
//   a cycle over all 31 value bits, a scan state finds the leading digit,
//   then one digit item is issued per cycle unless the receiver stalls.
//   s_tready is high only while idle; the next value may be accepted while
//   the last digit item still waits in the output register.
//   When the receiver stalls, the output register holds its item and the
//   digit sequencer waits. Reset empties the output register and returns
//   the sequencer to idle; no other state survives between values.
// ----------------------------------------------------------------------------
module binary_to_zoned_decimal_text
	import bzd_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [30:0] value, [31] zero pad
	// master stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] zone_char, [15:8] digit_char
	output logic                  m_tlast,   // last_pair
	output logic                  m_tuser    // empty_result
);

	localparam int W     = (MAX_DIGITS < BCD_MAX) ? MAX_DIGITS : BCD_MAX;
	localparam int IDX_W = (W > 1) ? $clog2(W) : 1;
	localparam logic [SHIFT_CNT_W-1:0] LAST_SHIFT = SHIFT_CNT_W'(VALUE_W - 1);

	bzd_state_t              state_q;
	logic [VALUE_W-1:0]      bin_q;
	logic [W-1:0][3:0]       bcd_q;
	logic                    ovf_q;
	logic                    empty_q;
	logic [SHIFT_CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]        idx_q;

	logic                    out_valid_q;
	logic [7:0]              zone_q;
	logic [7:0]              digit_q;
	logic                    last_q;
	logic                    user_q;

	logic                    in_acc;
	logic                    out_free;
	logic [W-1:0][3:0]       adj;
	logic [4*W-1:0]          adj_flat;
	logic [IDX_W-1:0]        lead_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// add-3 correction on every BCD digit ahead of the shift
	always_comb begin
		for (int i = 0; i < W; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		adj_flat = adj;
	end

	// leading nonzero digit inside the window
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < W; i++) begin
			if (bcd_q[i] != 4'd0) begin
				lead_idx = IDX_W'(i);
			end
		end
	end

	// sequencer and conversion datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SHIFT;
						cnt_q   <= '0;
					end
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_SHIFT) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free && (idx_q == '0)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers of the converter
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					bin_q   <= s_tdata[VALUE_W-1:0];
					bcd_q   <= '0;
					ovf_q   <= 1'b0;
					empty_q <= (s_tdata[VALUE_W-1:0] == '0);
				end
			end
			ST_SHIFT: begin
				bcd_q <= {adj_flat[4*W-2:0], bin_q[VALUE_W-1]};
				bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
				ovf_q <= ovf_q | adj_flat[4*W-1];
			end
			ST_SCAN: begin
				idx_q <= ovf_q ? IDX_W'(W - 1) : lead_idx;
			end
			ST_EMIT: begin
				if (out_free && (idx_q != '0)) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			zone_q  <= ZONE_CHAR;
			digit_q <= empty_q ? NUL_CHAR : (ZERO_CHAR + {4'd0, bcd_q[idx_q]});
			last_q  <= (idx_q == '0);
			user_q  <= empty_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {digit_q, zone_q};
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("converter ready right after taking an item");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("empty item not marked last");

	a_zone_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == ZONE_CHAR))
		else $error("zone byte is not F");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |->
			((m_tdata[15:8] >= ZERO_CHAR) && (m_tdata[15:8] <= NINE_CHAR)))
		else $error("digit byte outside 0..9");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q <= IDX_W'(W - 1)))
		else $error("digit index beyond window");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks binary_to_zoned_decimal_text: every accepted value is turned into
// the expected list of ('F', digit) pairs by a predictor in this file.
// Each output item is compared, field by field, with the oldest pair still
// expected. Directed values come first, then random values of every digit
// length, with random gaps on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import bzd_pkg::*;

	localparam int DIGIT_WINDOW = MAX_DIGITS_DEF;
	localparam int IDLE_LIMIT   = 2000;   // cycles with no item moved on either side
	localparam int DRAIN_CYCLES = 60;     // extra wait once no expected pair is left
	localparam int PRINT_CAP    = 40;

	// One expected digit pair
	typedef struct packed {
		logic [7:0] zone;
		logic [7:0] digit;
		logic       last;
		logic       empty;
	} digit_pair_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;    // [30:0] value, [31] pad
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;    // [7:0] zone_char, [15:8] digit_char
	logic                  m_tlast;    // last_pair
	logic                  m_tuser;    // empty_result

	digit_pair_t expected_pairs[$];
	digit_pair_t oldest_pair;
	int          mismatches  = 0;
	int          idle_cycles = 0;
	bit          tx_gaps     = 1'b0;
	bit          rx_stalls   = 1'b0;
	int          hold_off    = 0;
	int          stall_left  = 0;

	binary_to_zoned_decimal_text #(
		.MAX_DIGITS(DIGIT_WINDOW)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Known input levels from time zero
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
	end

	// Prints one line per mismatch, up to a cap, and counts all of them
	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_CAP)
			$display("%0t ERROR: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic longint unsigned pow10(input int n);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < n; i++)
			p = p * 10;
		return p;
	endfunction

	// Expected digit pairs of one value, most significant first
	task automatic predict_digits(input logic [IN_DATA_W-1:0] word);
		logic [VALUE_W-1:0] v;
		logic [3:0]         dig [0:19];
		int                 ndig;
		int                 count;
		digit_pair_t        p;
		v    = word[VALUE_W-1:0];    // pad bit is ignored
		ndig = 0;
		if (v == '0) begin
			p = '{zone: ZONE_CHAR, digit: NUL_CHAR, last: 1'b1, empty: 1'b1};
			expected_pairs.push_back(p);
			return;
		end
		while (v != '0) begin
			dig[ndig] = 4'(v % 10);
			v         = v / 10;
			ndig++;
		end
		// only the low digits fit in the window
		count = (ndig > DIGIT_WINDOW) ? DIGIT_WINDOW : ndig;
		for (int k = 0; k < count; k++) begin
			p.zone  = ZONE_CHAR;
			p.digit = ZERO_CHAR + 8'(dig[count - 1 - k]);
			p.last  = (k == count - 1);
			p.empty = 1'b0;
			expected_pairs.push_back(p);
		end
	endtask

	// Output check, input prediction and watchdog, all at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_pairs.size() == 0) begin
					report_mismatch("unexpected item, digit_char", m_tdata[15:8], -1);
				end else begin
					oldest_pair = expected_pairs.pop_front();
					if (m_tdata[7:0] !== oldest_pair.zone)
						report_mismatch("zone_char", m_tdata[7:0], oldest_pair.zone);
					if (m_tdata[15:8] !== oldest_pair.digit)
						report_mismatch("digit_char", m_tdata[15:8], oldest_pair.digit);
					if (m_tlast !== oldest_pair.last)
						report_mismatch("last_pair", m_tlast, oldest_pair.last);
					if (m_tuser !== oldest_pair.empty)
						report_mismatch("empty_result", m_tuser, oldest_pair.empty);
				end
			end
			if (s_tvalid && s_tready)
				predict_digits(s_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 45);
	endfunction

	// Receiver: long hold-off on request, else random stalls when enabled
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready = 1'b0;
				hold_off--;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (rx_stalls && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Offers one item and returns at the edge where it is taken
	task automatic send_value(input logic [IN_DATA_W-1:0] word);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata  = $urandom;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = word;
		do @(posedge clk); while (!s_tready);
	endtask

	// Random value: mostly a random digit length, some full-width, some
	// with many zero digits, a few zeros; the pad bit is set now and then
	function automatic logic [IN_DATA_W-1:0] random_value();
		int                  r;
		int                  len;
		longint unsigned     lo;
		longint unsigned     hi;
		longint unsigned     acc;
		logic [IN_DATA_W-1:0] word;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			len = $urandom_range(1, 10);
			lo  = pow10(len - 1);
			hi  = pow10(len) - 1;
			if (hi > 64'd2147483647)
				hi = 64'd2147483647;
			word = $urandom_range(32'(hi), 32'(lo));
		end else if (r < 80) begin
			word = {1'b0, 31'($urandom)};
		end else if (r < 95) begin
			// zeros inside the number
			len = $urandom_range(2, 9);
			acc = $urandom_range(1, 9);
			for (int i = 1; i < len; i++)
				acc = acc * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
			word = 32'(acc);
		end else begin
			word = '0;
		end
		if ($urandom_range(0, 3) == 0)
			word[IN_DATA_W-1] = 1'b1;
		return word;
	endfunction

	// Field extremes, zeros inside numbers, pad bit and digit counts 1 to 5, 9 and 10
	task automatic test_directed();
		logic [IN_DATA_W-1:0] values[$];
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		values = '{32'd0, 32'h8000_0000, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
			32'd105, 32'd1000, 32'd10001, 32'd999999999, 32'd1000000000,
			32'd1000000007, 32'd2147483647, 32'h8000_0069, 32'h4000_0000,
			32'h5555_5555, 32'h2AAA_AAAA, 32'hFFFF_FFFF, 32'd20};
		foreach (values[i])
			send_value(values[i]);
	endtask

	// Random values with gaps on both streams
	task automatic test_random_gaps(input int n);
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		repeat (n)
			send_value(random_value());
	endtask

	// Random values with no idling on either side
	task automatic test_back_to_back(input int n);
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		repeat (n)
			send_value(random_value());
	endtask

	// Receiver holds off while values keep coming, so the input stalls
	task automatic test_receiver_hold(input int n);
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		@(negedge clk);
		hold_off = 300;
		repeat (n)
			send_value(random_value());
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_gaps(90);
		test_back_to_back(30);
		test_receiver_hold(20);
		test_random_gaps(20);

		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
